/* rtl/core/bldc_six_step_commutator_defines.svh */
// Assertion macros for the six-step commutator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BLDC_SIX_STEP_COMMUTATOR_DEFINES_SVH
`define BLDC_SIX_STEP_COMMUTATOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define BSSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BSSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bssc_pkg.sv */
// Shared types, constants and step tables for the six-step commutator.
// No dependencies; imported by every module of the block.
`default_nettype none

package bssc_pkg;

  localparam longint unsigned SLOW_CLOCK_HZ = 64'd3200000;
  localparam longint unsigned FAST_CLOCK_HZ = 64'd32000000;
  localparam longint unsigned POLE_COUNT    = 64'd8;
  localparam longint unsigned SECONDS_PER_MIN = 64'd60;
  localparam longint unsigned COUNT_MAX     = 64'hFFFF;

  localparam logic [15:0] THRESH_RESET = 16'd2500;
  localparam logic [14:0] SPEED_MAX    = 15'h7FFF;

  // rounded quotient: (2*60*f + P*c) / (2*P*c)
  localparam longint unsigned K_SLOW = 64'd2 * SECONDS_PER_MIN * SLOW_CLOCK_HZ;
  localparam longint unsigned K_FAST = 64'd2 * SECONDS_PER_MIN * FAST_CLOCK_HZ;
  localparam longint unsigned K_MAX  = (K_SLOW > K_FAST) ? K_SLOW : K_FAST;
  localparam longint unsigned PC_MAX = POLE_COUNT * COUNT_MAX;

  localparam int PC_W  = $clog2(PC_MAX + 64'd1);
  localparam int DEN_W = PC_W + 1;
  localparam int NUM_W = $clog2(K_MAX + PC_MAX + 64'd1);
  localparam int CNT_W = $clog2(NUM_W);

  // function codes
  localparam logic [1:0] FUNC_DRIVE = 2'd0;
  localparam logic [1:0] FUNC_HALL  = 2'd1;
  localparam logic [1:0] FUNC_PWM   = 2'd2;
  localparam logic [1:0] FUNC_SPEED = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] drive_command;
    logic [2:0]         hall_bits;
    logic [13:0]        pwm_count;
    logic [15:0]        slow_count;
    logic [15:0]        fast_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         phase_enable;
    logic [2:0]         phase_level;
    logic               pwm_high;
    logic signed [15:0] speed_signed;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_finish;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic speed_item;
  } dp_stat_t;

  function automatic logic [2:0] step_enable(input logic [2:0] s);
    logic [2:0] r;
    case (s)
      3'd1:    r = 3'd6;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd5;
      3'd4:    r = 3'd5;
      3'd5:    r = 3'd3;
      3'd6:    r = 3'd6;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] step_level(input logic [2:0] s);
    logic [2:0] r;
    case (s)
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd1;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd4;
      3'd5:    r = 3'd2;
      3'd6:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bssc_dp.sv */
// Datapath: drive/step/bridge state, speed divider and result register.
// Depends on bssc_pkg; driven by bssc_ctrl commands.
`default_nettype none

module bssc_dp import bssc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire in_item_t    in_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  output out_item_t        out_data_o
);

  logic [15:0] thresh_q;
  logic [15:0] duty_q, duty_d;
  logic        rev_q, rev_d;
  logic [2:0]  step_q, step_d;
  logic [14:0] speed_q, speed_d;
  logic [2:0]  enable_q, enable_d;
  logic [2:0]  level_q, level_d;
  logic        high_q, high_d;

  // divider
  logic [NUM_W-1:0] num_q, num_d;   // dividend in, quotient out
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic             zero_q, zero_d;

  logic             use_slow;
  logic [15:0]      sel_count;
  logic [PC_W-1:0]  pc;
  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [15:0]      sp;

  out_item_t out_q, out_d;

  assign stat_o.speed_item = (in_data_i.func == FUNC_SPEED);

  assign use_slow  = in_data_i.slow_count > thresh_q;
  assign sel_count = use_slow ? in_data_i.slow_count : in_data_i.fast_count;
  assign pc        = PC_W'(sel_count) * PC_W'(POLE_COUNT);

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign qbit  = trial >= {1'b0, den_q};

  always_comb begin
    duty_d   = duty_q;
    rev_d    = rev_q;
    step_d   = step_q;
    speed_d  = speed_q;
    enable_d = enable_q;
    level_d  = level_q;
    high_d   = high_q;
    num_d    = num_q;
    den_d    = den_q;
    rem_d    = rem_q;
    zero_d   = zero_q;

    if (cmd_i.accept) begin
      case (in_data_i.func)
        FUNC_DRIVE: begin
          rev_d  = in_data_i.drive_command[15];
          duty_d = in_data_i.drive_command[15] ? (~in_data_i.drive_command + 16'd1)
                                               : in_data_i.drive_command;
        end
        FUNC_HALL: begin
          step_d = rev_q ? ~in_data_i.hall_bits : in_data_i.hall_bits;
        end
        FUNC_PWM: begin
          if ({2'b00, in_data_i.pwm_count} < duty_q) begin
            high_d = 1'b1;
            if (step_q != 3'd0 && step_q != 3'd7) begin
              enable_d = step_enable(step_q);
              level_d  = step_level(step_q);
            end
          end else begin
            high_d  = 1'b0;
            level_d = 3'd0;
          end
        end
        default: begin
          num_d  = NUM_W'(use_slow ? K_SLOW : K_FAST) + NUM_W'(pc);
          den_d  = {pc, 1'b0};
          rem_d  = '0;
          zero_d = (sel_count == 16'd0);
        end
      endcase
    end

    // restoring division, one quotient bit per step
    if (cmd_i.div_step) begin
      rem_d = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], qbit};
    end

    if (cmd_i.div_finish) begin
      speed_d = (zero_q || num_q > NUM_W'(SPEED_MAX)) ? SPEED_MAX : num_q[14:0];
    end
  end

  assign sp = rev_q ? (16'd0 - {1'b0, speed_q}) : {1'b0, speed_q};

  always_comb begin
    out_d = out_q;
    if (cmd_i.load_out) begin
      out_d.phase_enable = enable_q;
      out_d.phase_level  = level_q;
      out_d.pwm_high     = high_q;
      out_d.speed_signed = sp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      duty_q   <= '0;
      rev_q    <= 1'b0;
      step_q   <= '0;
      speed_q  <= '0;
      enable_q <= '0;
      level_q  <= '0;
      high_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_data_i;
      end
      duty_q   <= duty_d;
      rev_q    <= rev_d;
      step_q   <= step_d;
      speed_q  <= speed_d;
      enable_q <= enable_d;
      level_q  <= level_d;
      high_q   <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    zero_q <= zero_d;
    out_q  <= out_d;
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* rtl/core/bssc_ctrl.sv */
// Controller: sequences accept, division steps and result load.
// Depends on bssc_pkg; commands bssc_dp.
`default_nettype none

module bssc_ctrl import bssc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.speed_item) begin
            state_d = ST_DIV;
            cnt_d   = CNT_W'(NUM_W - 1);
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_FIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = ST_LOAD;
      end
      ST_LOAD: begin
        // result register free or draining this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/bldc_six_step_commutator.sv */
// Top level of the six-step BLDC commutator with speed measurement.
// Depends on bssc_pkg, bssc_ctrl, bssc_dp and the assertion macro header.
//
//   port group     direction  flow control       payload
//   in_*           sink       in_valid_i/stall_o in_item_t  (func + operands)
//   out_*          source     out_valid_o/stall_i out_item_t (bridge + speed)
//   cfg_*          sink       cfg_we_i           16-bit speed switch threshold
//
// Sequence: drive, hall and PWM items are accepted, then their result loads.
// Speed items are accepted, then the restoring divider retires one quotient
// bit per cycle over NUM_W steps, then a finish step and the result load.
// Reset: async active low; control/motor state clears, threshold goes to 2500.
// Stalls: a valid result stays in its register while out_stall_i is high; the
// next item is still taken; its result waits in the load step until it drains.
`default_nettype none

`include "bldc_six_step_commutator_defines.svh"

module bldc_six_step_commutator import bssc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item transfer
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  // result transfer
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  // threshold register write
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: idle -> (divide -> finish) -> load result
  bssc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // motor state, step table lookup, speed divider, result register
  bssc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

  // one item in flight: stall goes up right after every transfer in
  `BSSC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                   "input taken while previous item still in progress")

  // a speed item still has the input stalled when its division finishes
  `BSSC_ASSERT_IMP(a_div_length,
                   in_valid_i && !in_stall_o && in_data_i.func == FUNC_SPEED,
                   ##(NUM_W + 1) in_stall_o,
                   "speed division ended early")

  // speed magnitude saturates at 32767, so the most negative code never shows
  `BSSC_ASSERT_IMP(a_speed_range, out_valid_o, out_data_o.speed_signed != 16'sh8000,
                   "speed result out of saturated range")

endmodule

`default_nettype wire

/* tb/commutator_checker.sv */
`timescale 1ns / 100ps
// Result checker for the six-step commutator: predicts each result from the
// accepted input transfers and compares it. Depends on bssc_pkg.
module commutator_checker import bssc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output int          pending_o,
  output int          fail_count_o
);

  localparam longint unsigned SLOW_TICK_HZ    = 64'd3200000;
  localparam longint unsigned FAST_TICK_HZ    = 64'd32000000;
  localparam longint unsigned POLES           = 64'd8;
  localparam longint unsigned SEC_PER_MINUTE  = 64'd60;
  localparam longint unsigned RPM_CEIL        = 64'd32767;
  localparam int              MAX_PRINTED     = 50;

  // bridge tables, step 7 down to step 0
  localparam logic [23:0] ENABLE_BY_STEP =
    {3'd0, 3'd6, 3'd3, 3'd5, 3'd5, 3'd3, 3'd6, 3'd0};
  localparam logic [23:0] LEVEL_BY_STEP =
    {3'd0, 3'd4, 3'd2, 3'd4, 3'd1, 3'd1, 3'd2, 3'd0};

  logic [15:0] switch_threshold;
  logic [15:0] duty_mag;
  logic        reversing;
  logic [2:0]  comm_step;
  logic [14:0] rpm_value;
  logic [2:0]  bridge_en;
  logic [2:0]  bridge_lvl;
  logic        pwm_on;

  out_item_t expected_results[$];
  int        mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t checker: %s", $time, msg);
    end
  endtask

  // half-up rounded rpm, saturated on zero count or overflow
  function automatic logic [14:0] rpm_from_ticks(input longint unsigned tick_hz,
                                                 input longint unsigned ticks);
    longint unsigned span;
    longint unsigned rpm;
    if (ticks == 0) begin
      return 15'(RPM_CEIL);
    end
    span = POLES * ticks;
    rpm  = (64'd2 * tick_hz * SEC_PER_MINUTE + span) / (64'd2 * span);
    return (rpm > RPM_CEIL) ? 15'(RPM_CEIL) : 15'(rpm);
  endfunction

  task automatic advance_commutation(input in_item_t it);
    logic [15:0] cmd;
    out_item_t   r;
    cmd = it.drive_command;
    case (it.func)
      FUNC_DRIVE: begin
        duty_mag  = cmd[15] ? (~cmd + 16'd1) : cmd;
        reversing = cmd[15];
      end
      FUNC_HALL: begin
        comm_step = reversing ? ~it.hall_bits : it.hall_bits;
      end
      FUNC_PWM: begin
        if ({2'b00, it.pwm_count} < duty_mag) begin
          pwm_on = 1'b1;
          // unused steps leave the bridge as it was
          if (comm_step != 3'd0 && comm_step != 3'd7) begin
            bridge_en  = ENABLE_BY_STEP[int'(comm_step) * 3 +: 3];
            bridge_lvl = LEVEL_BY_STEP[int'(comm_step) * 3 +: 3];
          end
        end else begin
          pwm_on     = 1'b0;
          bridge_lvl = 3'd0;
        end
      end
      FUNC_SPEED: begin
        if (it.slow_count > switch_threshold) begin
          rpm_value = rpm_from_ticks(SLOW_TICK_HZ, longint'(it.slow_count));
        end else begin
          rpm_value = rpm_from_ticks(FAST_TICK_HZ, longint'(it.fast_count));
        end
      end
      default: ;
    endcase
    r.phase_enable = bridge_en;
    r.phase_level  = bridge_lvl;
    r.pwm_high     = pwm_on;
    r.speed_signed = reversing ? (16'd0 - {1'b0, rpm_value}) : {1'b0, rpm_value};
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      switch_threshold = 16'd2500;
      duty_mag         = '0;
      reversing        = 1'b0;
      comm_step        = '0;
      rpm_value        = '0;
      bridge_en        = '0;
      bridge_lvl       = '0;
      pwm_on           = 1'b0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        switch_threshold = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report("result transfer with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.phase_enable !== want.phase_enable)
            report($sformatf("phase_enable got %0d, expected %0d",
                             out_data_i.phase_enable, want.phase_enable));
          if (out_data_i.phase_level !== want.phase_level)
            report($sformatf("phase_level got %0d, expected %0d",
                             out_data_i.phase_level, want.phase_level));
          if (out_data_i.pwm_high !== want.pwm_high)
            report($sformatf("pwm_high got %0d, expected %0d",
                             out_data_i.pwm_high, want.pwm_high));
          if (out_data_i.speed_signed !== want.speed_signed)
            report($sformatf("speed_signed got %0d, expected %0d",
                             out_data_i.speed_signed, want.speed_signed));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_commutation(in_data_i);
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

/* tb/tb_bldc_six_step_commutator.sv */
`timescale 1ns / 100ps
// Top of the six-step commutator testbench: clock, reset, stimulus and verdict.
// Depends on bssc_pkg, the commutator RTL and commutator_checker.
module tb_bldc_six_step_commutator import bssc_pkg::*; ;

  // Random part of the run, split evenly over the threshold settings.
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASES       = 4;
  // Idle tail before the verdict, so a late or stray result can still show up.
  localparam int DRAIN_CYCLES = 40;
  // Cycles without any transfer before the run is declared hung. Worst honest
  // case is the longest sender gap, a full divide and the longest solid stall
  // back to back, so this leaves a wide margin.
  localparam int IDLE_LIMIT   = 5000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_data  = '0;

  int pending;
  int fail_count;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  bldc_six_step_commutator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  commutator_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Receiver back-pressure: a mode is held for a random stretch of cycles.
  // Mode 0 never stalls, 1 stalls lightly, 2 about half the time, 3 holds the
  // stall for the whole stretch so a finished result sits in the output reg.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(1, 150);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= 1'b1;
    endcase
  end

  // Watchdog: any input or result transfer restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic in_item_t make_item(input logic [1:0]  func,
                                         input logic [15:0] cmd,
                                         input logic [2:0]  hall,
                                         input logic [13:0] pwm,
                                         input logic [15:0] slow,
                                         input logic [15:0] fast);
    in_item_t it;
    it.func          = func;
    it.drive_command = cmd;
    it.hall_bits     = hall;
    it.pwm_count     = pwm;
    it.slow_count    = slow;
    it.fast_count    = fast;
    return it;
  endfunction

  // Random transfer shaped like a control loop: mostly hall samples and PWM
  // updates, some drive changes and speed captures. Unused operands stay
  // fully random so every bit toggles.
  function automatic in_item_t random_item(input logic [15:0] thr);
    in_item_t    it;
    logic [15:0] mag;
    int          pick;
    int          near;
    it.func          = 2'($urandom);
    it.drive_command = 16'($urandom);
    it.hall_bits     = 3'($urandom);
    it.pwm_count     = 14'($urandom);
    it.slow_count    = 16'($urandom);
    it.fast_count    = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.func = FUNC_DRIVE;
      // keep most duty values inside the PWM counter range
      if ($urandom_range(0, 3) != 0) begin
        mag = 16'($urandom_range(0, 12000));
        it.drive_command = ($urandom_range(0, 1) == 1) ? (16'd0 - mag) : mag;
      end
    end else if (pick < 35) begin
      it.func = FUNC_HALL;
    end else if (pick < 80) begin
      it.func = FUNC_PWM;
      if ($urandom_range(0, 7) != 0) begin
        it.pwm_count = 14'($urandom_range(0, 9999));
      end
    end else begin
      it.func = FUNC_SPEED;
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          // straddle the timer switch point
          near = int'(thr) + int'($urandom_range(0, 4)) - 2;
          if (near < 0) near = 0;
          if (near > 65535) near = 65535;
          it.slow_count = 16'(near);
        end
        2: begin
          // tiny counts: zero and overflow saturation
          it.slow_count = 16'($urandom_range(0, 3));
          it.fast_count = 16'($urandom_range(0, 3));
        end
        default: begin
          it.slow_count = 16'($urandom_range(0, int'(thr)));
        end
      endcase
    end
    return it;
  endfunction

  // Sender: bursts of back-to-back transfers separated by random gaps.
  // Valid is held until the transfer completes; data only moves after that.
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every predicted result has been transferred. Starts with an
  // edge so the checker has seen the last input transfer.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // Threshold writes only happen with the block idle.
  task automatic write_threshold(input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic [15:0] thr;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset threshold of 2500.
    // speed: zero fast count, just above switch point, huge fast speed,
    // slowest slow speed, full-scale fast count
    send_item(make_item(FUNC_SPEED, 16'd0, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_SPEED, 16'd0, 3'd0, 14'd0, 16'd2501, 16'd0));
    send_item(make_item(FUNC_SPEED, 16'd0, 3'd0, 14'd0, 16'd2500, 16'd1));
    send_item(make_item(FUNC_SPEED, 16'd0, 3'd0, 14'd0, 16'hFFFF, 16'd5));
    send_item(make_item(FUNC_SPEED, 16'd0, 3'd0, 14'd0, 16'd7, 16'hFFFF));
    // largest forward command, step 5, PWM counter at zero and at full scale
    send_item(make_item(FUNC_DRIVE, 16'h7FFF, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_HALL, 16'd0, 3'd5, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'h3FFF, 16'd0, 16'd0));
    // high/low boundary at the duty magnitude
    send_item(make_item(FUNC_DRIVE, 16'd5000, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'd4999, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'd5000, 16'd0, 16'd0));
    // unused steps zero and seven keep the bridge
    send_item(make_item(FUNC_HALL, 16'd0, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_HALL, 16'd0, 3'd7, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'd1, 16'd0, 16'd0));
    // most negative command: reverse, inverted hall, negative speed
    send_item(make_item(FUNC_DRIVE, 16'h8000, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_HALL, 16'd0, 3'd2, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'h3FFF, 16'd0, 16'd0));
    send_item(make_item(FUNC_SPEED, 16'd0, 3'd0, 14'd0, 16'd3000, 16'd0));
    // smallest reverse duty
    send_item(make_item(FUNC_DRIVE, 16'hFFFF, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'd1, 16'd0, 16'd0));
    // zero duty never reaches the high part
    send_item(make_item(FUNC_DRIVE, 16'd0, 3'd0, 14'd0, 16'd0, 16'd0));
    send_item(make_item(FUNC_PWM, 16'd0, 3'd0, 14'd0, 16'd0, 16'd0));
    in_valid <= 1'b0;
    wait_drained();

    // Random part over several threshold settings, extremes included.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       thr = 16'd0;
        1:       thr = 16'hFFFF;
        2:       thr = 16'($urandom);
        default: thr = 16'd1000;
      endcase
      write_threshold(thr);
      repeat (RANDOM_ITEMS / PHASES) send_item(random_item(thr));
      in_valid <= 1'b0;
      wait_drained();
    end

    // let any late or stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bssc_pkg.sv
rtl/core/bssc_dp.sv
rtl/core/bssc_ctrl.sv
rtl/core/bldc_six_step_commutator.sv
tb/commutator_checker.sv
tb/tb_bldc_six_step_commutator.sv
